### hdl/mslcg_pkg.sv
// Shared types and constants for the multi-stream LCG range draw core.
`default_nettype none
package mslcg_pkg;

    localparam int DATA_W    = 32;
    localparam int STREAM_W  = 3;
    localparam int ACTION_W  = 2;
    localparam int MULT_W    = 15;
    localparam int COUNT_W   = DATA_W + 1;
    localparam int FRAC_SHIFT = 10;
    localparam int FRAC_BITS  = 22;
    localparam int PROD_W    = COUNT_W + FRAC_BITS;

    localparam logic [MULT_W-1:0] LCG_MULT     = 15'h41A7;
    localparam logic [DATA_W-1:0] SEED_DEFAULT = 32'd999;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEED    = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_DRAW    = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_SCALE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic calc;
        logic scale;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic is_draw;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

### hdl/mslcg_if.sv
// Request and response channel interfaces.
`default_nettype none
interface mslcg_req_if;
    logic                              valid;
    logic                              ready;
    logic [mslcg_pkg::ACTION_W-1:0]    action;
    logic [mslcg_pkg::STREAM_W-1:0]    stream;
    logic signed [mslcg_pkg::DATA_W-1:0] seed_value;
    logic signed [mslcg_pkg::DATA_W-1:0] first_bound;
    logic signed [mslcg_pkg::DATA_W-1:0] second_bound;

    modport source (output valid, action, stream, seed_value, first_bound, second_bound,
                    input ready);
    modport sink   (input valid, action, stream, seed_value, first_bound, second_bound,
                    output ready);
endinterface

interface mslcg_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [mslcg_pkg::DATA_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface
`default_nettype wire

### hdl/mslcg_ctrl.sv
// Controller state machine sequencing one request through the datapath.
`default_nettype none
module mslcg_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire mslcg_pkg::t_dp_sts i_sts,
    output mslcg_pkg::t_dp_cmd      o_cmd
);

    mslcg_pkg::t_state r_state;
    mslcg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mslcg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mslcg_pkg::S_IDLE: begin
                if (i_req_valid) n_state = mslcg_pkg::S_CALC;
            end
            mslcg_pkg::S_CALC: begin
                n_state = i_sts.is_draw ? mslcg_pkg::S_SCALE : mslcg_pkg::S_DONE;
            end
            mslcg_pkg::S_SCALE: begin
                n_state = mslcg_pkg::S_DONE;
            end
            mslcg_pkg::S_DONE: begin
                if (i_sts.out_free) n_state = mslcg_pkg::S_IDLE;
            end
            default: begin
                n_state = mslcg_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req_ready  = 1'b0;
        o_cmd        = '0;
        case (r_state)
            mslcg_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            mslcg_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
            end
            mslcg_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
            end
            mslcg_pkg::S_DONE: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/mslcg_dp.sv
// Datapath: stream state memory, LCG step, range scaling and output register.
`default_nettype none
module mslcg_dp #(
    parameter int NUM_STREAMS = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mslcg_pkg::t_dp_cmd                  i_cmd,
    output mslcg_pkg::t_dp_sts                       o_sts,
    input  wire logic [mslcg_pkg::ACTION_W-1:0]      i_action,
    input  wire logic [mslcg_pkg::STREAM_W-1:0]      i_stream,
    input  wire logic signed [mslcg_pkg::DATA_W-1:0] i_seed_value,
    input  wire logic signed [mslcg_pkg::DATA_W-1:0] i_first_bound,
    input  wire logic signed [mslcg_pkg::DATA_W-1:0] i_second_bound,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [mslcg_pkg::DATA_W-1:0]      o_out_value
);

    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int EXT_W = (IDX_W > mslcg_pkg::STREAM_W) ? IDX_W : mslcg_pkg::STREAM_W;
    localparam int DW    = mslcg_pkg::DATA_W;

    logic [DW-1:0]          r_mem [NUM_STREAMS];
    logic [NUM_STREAMS-1:0] r_written;

    logic [EXT_W-1:0] w_stream_ext;
    logic [IDX_W-1:0] w_addr;
    logic             w_in_range;

    mslcg_pkg::t_action r_action;
    logic               r_in_range;
    logic [IDX_W-1:0]   r_addr;
    logic [DW-1:0]      r_seed;
    logic signed [DW-1:0] r_first;
    logic signed [DW-1:0] r_second;
    logic [DW-1:0]      r_mem_q;
    logic               r_mem_vld;

    logic [DW-1:0]      r_new_state;
    logic [DW-1:0]      r_base;
    logic [mslcg_pkg::COUNT_W-1:0] r_count;
    logic [DW-1:0]      r_off;

    logic               r_out_valid;
    logic [DW-1:0]      r_out_value;

    logic [DW-1:0]      w_cur;
    logic [DW-1:0]      w_step;
    logic [DW-1:0]      n_new_state;
    logic               w_swap;
    logic signed [DW:0] w_lo;
    logic signed [DW:0] w_hi;
    logic [DW:0]        w_span;
    logic [mslcg_pkg::PROD_W-1:0] w_prod;
    logic [DW-1:0]      n_out_value;

    assign w_stream_ext = EXT_W'(i_stream);
    assign w_addr       = w_stream_ext[IDX_W-1:0];
    assign w_in_range   = (32'(i_stream) < 32'(NUM_STREAMS));

    // request capture and state read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action   <= mslcg_pkg::t_action'(i_action);
            r_in_range <= w_in_range;
            r_addr     <= w_addr;
            r_seed     <= i_seed_value;
            r_first    <= i_first_bound;
            r_second   <= i_second_bound;
            r_mem_q    <= r_mem[w_addr];
            r_mem_vld  <= w_in_range && r_written[w_addr];
        end
        if (i_cmd.finish && r_in_range) begin
            r_mem[r_addr] <= r_new_state;
        end
    end

    // entries never written read as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.finish && r_in_range) begin
            r_written[r_addr] <= 1'b1;
        end
    end

    assign w_cur  = r_mem_vld ? r_mem_q : mslcg_pkg::SEED_DEFAULT;
    assign w_step = w_cur * DW'(mslcg_pkg::LCG_MULT);

    always_comb begin
        case (r_action)
            mslcg_pkg::ACT_SEED: begin
                n_new_state = (r_seed != '0) ? r_seed : mslcg_pkg::SEED_DEFAULT;
            end
            mslcg_pkg::ACT_ADVANCE: begin
                n_new_state = w_step;
            end
            mslcg_pkg::ACT_DRAW: begin
                n_new_state = w_step;
            end
            default: begin
                n_new_state = w_cur;
            end
        endcase
    end

    assign w_swap = (r_second < r_first);
    assign w_lo   = w_swap ? {r_second[DW-1], r_second} : {r_first[DW-1], r_first};
    assign w_hi   = w_swap ? {r_first[DW-1], r_first} : {r_second[DW-1], r_second};
    assign w_span = w_hi - w_lo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_new_state <= n_new_state;
            r_base      <= w_lo[DW-1:0];
            r_count     <= mslcg_pkg::COUNT_W'(w_span) + mslcg_pkg::COUNT_W'(1);
        end
    end

    // count * m, m being the top fraction bits of the new state
    assign w_prod = mslcg_pkg::PROD_W'(r_count)
                  * mslcg_pkg::PROD_W'(r_new_state[DW-1:mslcg_pkg::FRAC_SHIFT]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_off <= w_prod[mslcg_pkg::FRAC_BITS +: DW];
        end
    end

    always_comb begin
        if (!r_in_range) begin
            n_out_value = '0;
        end else if (r_action == mslcg_pkg::ACT_DRAW) begin
            n_out_value = r_base + r_off;
        end else begin
            n_out_value = r_new_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_value <= n_out_value;
        end
    end

    assign o_sts.is_draw  = r_in_range && (r_action == mslcg_pkg::ACT_DRAW);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_value    = r_out_value;

endmodule
`default_nettype wire

### hdl/multi_stream_lcg_range_draw_core.sv
// Sequence per request: capture and read, LCG step, range multiply (draws to a valid stream only),
// write-back and output load; the controller takes no new request until the output is loaded,
// and that load waits while a previous result is still unaccepted.
// Reset: synchronous active low; every stream reads as 999 until first written,
// tracked by per-stream written flags, so no clearing pass is needed.
`default_nettype none
module multi_stream_lcg_range_draw_core #(
    parameter int NUM_STREAMS = 5
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mslcg_req_if.sink    i_req,
    mslcg_rsp_if.source  o_rsp
);

    mslcg_pkg::t_dp_cmd w_cmd;
    mslcg_pkg::t_dp_sts w_sts;
    logic               w_req_ready;

    assign i_req.ready = w_req_ready;

    mslcg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mslcg_dp #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_req.action),
        .i_stream       (i_req.stream),
        .i_seed_value   (i_req.seed_value),
        .i_first_bound  (i_req.first_bound),
        .i_second_bound (i_req.second_bound),
        .o_out_valid    (o_rsp.valid),
        .i_out_ready    (o_rsp.ready),
        .o_out_value    (o_rsp.value)
    );

endmodule
`default_nettype wire
